### src/fspid_pkg.sv
// ----------------------------------------------------------------------------
// Flywheel speed PID package
// Widths, reset values, register indexes, term and state codes, and clamp limits.
// ----------------------------------------------------------------------------
package fspid_pkg;

   localparam int FRAC_BITS = 24;

   localparam int TICK_W  = 16;
   localparam int RPM_W   = 16;
   localparam int DRIVE_W = 16;
   localparam int MAG_W   = 17;
   localparam int DVD_W   = 24;
   localparam int WIN_W   = 10;
   localparam int DTH_W   = 17;
   localparam int ETH_W   = 17;
   localparam int GAIN_W  = 32;
   localparam int ERR_W   = 18;
   localparam int ESUM_W  = 32;
   localparam int ACC_W   = 48;
   localparam int MC_W    = 32;
   localparam int HI_W    = MC_W + 1;
   localparam int PROD_W  = HI_W + GAIN_W;
   localparam int SUM_W   = 55;
   localparam int CNT_W   = 5;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW    = 3'd0,
      CSR_DELTA_THR = 3'd1,
      CSR_ERROR_THR = 3'd2,
      CSR_GAIN_P    = 3'd3,
      CSR_GAIN_I    = 3'd4,
      CSR_GAIN_D    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      TERM_P = 2'd0,
      TERM_I = 2'd1,
      TERM_D = 2'd2
   } term_type;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_DIV   = 11'b000_0000_0010,
      ST_RPM   = 11'b000_0000_0100,
      ST_ERR   = 11'b000_0000_1000,
      ST_DELTA = 11'b000_0001_0000,
      ST_INTEG = 11'b000_0010_0000,
      ST_MUL   = 11'b000_0100_0000,
      ST_MADD  = 11'b000_1000_0000,
      ST_FIN   = 11'b001_0000_0000,
      ST_DRV   = 11'b010_0000_0000,
      ST_DONE  = 11'b100_0000_0000
   } state_type;

   localparam logic [WIN_W-1:0]  WINDOW_RST    = WIN_W'(20);
   localparam logic [DTH_W-1:0]  DELTA_THR_RST = DTH_W'(50);
   localparam logic [ETH_W-1:0]  ERROR_THR_RST = ETH_W'(100);
   localparam logic [GAIN_W-1:0] GAIN_P_RST    = GAIN_W'(1258);
   localparam logic [GAIN_W-1:0] GAIN_I_RST    = GAIN_W'(12583);
   localparam logic [GAIN_W-1:0] GAIN_D_RST    = GAIN_W'(503316);

   localparam logic [ACC_W-1:0]  ACC_TOP  = ACC_W'(127) << FRAC_BITS;
   localparam logic [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [PROD_W-1:0] TERM_LIM = PROD_W'(1) << 52;
   localparam logic [PROD_W-1:0] TERM_NEG = ~TERM_LIM + PROD_W'(1);

   localparam logic [ACC_W-1:0]  DRIVE_MAX = ACC_W'(32767);
   localparam logic [ACC_W-1:0]  DRIVE_MIN = ~ACC_W'(32768) + ACC_W'(1);

endpackage

### src/flywheel_speed_pid_unit.sv
// ----------------------------------------------------------------------------
// Flywheel speed PID unit
// Measures flywheel speed from an encoder tick count and runs a PID update
// with conditional integration, using a bit-serial divider and multiplier.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                        Direction
//  req      req_valid, req_stall, req_encoder_ticks,     in (word in)
//           req_target_rpm
//  rsp      rsp_valid, rsp_stall, rsp_drive_power,       out (word out)
//           rsp_measured_rpm
//  csr      csr_wr_en, csr_index, csr_wdata              in (register write)
//
//  One word is in flight at a time: a new word is accepted only in the idle
//  state, after the previous word has moved on to the output register. A word
//  with a zero target skips the PID update, and the derivative term is added
//  only when the error is below the error threshold. The pace is set by the
//  restoring divider (one quotient bit each step) and the shared shift-add
//  multiplier. A word whose old accumulator is out of range skips the products.
//  Reset is synchronous; the output register lets a new word in while a
//  finished word waits on rsp_stall.
// ----------------------------------------------------------------------------
module flywheel_speed_pid_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [fspid_pkg::TICK_W-1:0] req_encoder_ticks,
   input  logic [fspid_pkg::RPM_W-1:0]       req_target_rpm,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [fspid_pkg::DRIVE_W-1:0] rsp_drive_power,
   output logic [fspid_pkg::RPM_W-1:0]       rsp_measured_rpm,
   input  logic                              csr_wr_en,
   input  logic [fspid_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fspid_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   fspid_pkg::state_type state_ff, state_in;
   fspid_pkg::term_type  term_ff, term_in;

   logic [fspid_pkg::WIN_W-1:0]  window_ff;
   logic [fspid_pkg::DTH_W-1:0]  delta_thr_ff;
   logic [fspid_pkg::ETH_W-1:0]  error_thr_ff;
   logic [fspid_pkg::GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;

   logic [fspid_pkg::ERR_W-1:0]  last_error_ff, last_error_in;
   logic [fspid_pkg::ESUM_W-1:0] error_sum_ff, error_sum_in;
   logic [fspid_pkg::ACC_W-1:0]  acc_ff, acc_in;

   logic [fspid_pkg::RPM_W-1:0]  target_ff, target_in;
   logic [fspid_pkg::DVD_W-1:0]  dvd_ff, dvd_in;
   logic [fspid_pkg::WIN_W-1:0]  rem_ff, rem_in;
   logic [fspid_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [fspid_pkg::RPM_W-1:0]  rpm_ff, rpm_in;
   logic [fspid_pkg::ERR_W-1:0]  err_ff, err_in;
   logic [fspid_pkg::ERR_W-1:0]  delta_ff, delta_in;
   logic                         d_en_ff, d_en_in;
   logic [fspid_pkg::MC_W-1:0]   mcand_ff, mcand_in;
   logic [fspid_pkg::HI_W-1:0]   mul_hi_ff, mul_hi_in;
   logic [fspid_pkg::GAIN_W-1:0] mul_lo_ff, mul_lo_in;
   logic [fspid_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [fspid_pkg::DRIVE_W-1:0] drive_ff, drive_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fspid_pkg::DRIVE_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic [fspid_pkg::RPM_W-1:0]   rsp_rpm_ff, rsp_rpm_in;

   logic [fspid_pkg::MAG_W-1:0]   mag;
   logic [fspid_pkg::DVD_W-1:0]   mag_x500;
   logic [fspid_pkg::WIN_W:0]     div_trial;
   logic                          div_fit;
   logic [fspid_pkg::HI_W-1:0]    mul_addend;
   logic [fspid_pkg::HI_W-1:0]    mul_sum;
   logic [fspid_pkg::PROD_W-1:0]  prod;
   logic [fspid_pkg::PROD_W-1:0]  term_clamped;
   logic [fspid_pkg::SUM_W-1:0]   term_value;
   logic [fspid_pkg::ERR_W-1:0]   adelta;
   logic [fspid_pkg::ESUM_W:0]    esum_wide;
   logic [fspid_pkg::ACC_W-1:0]   sum_clamped;
   logic [fspid_pkg::ACC_W-1:0]   acc_int;
   logic                          load_rsp;

   // Speed numerator: |ticks| * 500 = |ticks| * 512 - |ticks| * 12.
   always_comb begin
      mag = req_encoder_ticks[fspid_pkg::TICK_W-1]
            ? fspid_pkg::MAG_W'(-$signed({req_encoder_ticks[fspid_pkg::TICK_W-1],
                                          req_encoder_ticks}))
            : fspid_pkg::MAG_W'({1'b0, req_encoder_ticks});
      mag_x500 = (fspid_pkg::DVD_W'(mag) << 9) - (fspid_pkg::DVD_W'(mag) << 3)
                 - (fspid_pkg::DVD_W'(mag) << 2);
   end

   always_comb begin
      div_trial = {rem_ff, dvd_ff[fspid_pkg::DVD_W-1]};
      div_fit   = div_trial >= {1'b0, window_ff};
   end

   always_comb begin
      mul_addend = mul_lo_ff[0] ? {mcand_ff[fspid_pkg::MC_W-1], mcand_ff}
                                : '0;
      mul_sum    = mul_hi_ff + mul_addend;
      prod       = {mul_hi_ff, mul_lo_ff};
   end

   always_comb begin
      if ($signed(prod) > $signed(fspid_pkg::TERM_LIM)) begin
         term_clamped = fspid_pkg::TERM_LIM;
      end else if ($signed(prod) < $signed(fspid_pkg::TERM_NEG)) begin
         term_clamped = fspid_pkg::TERM_NEG;
      end else begin
         term_clamped = prod;
      end
      term_value = (term_ff == fspid_pkg::TERM_I) ? term_clamped[fspid_pkg::SUM_W-1:0]
                                                  : prod[fspid_pkg::SUM_W-1:0];
   end

   always_comb begin
      adelta = delta_ff[fspid_pkg::ERR_W-1] ? (~delta_ff + fspid_pkg::ERR_W'(1))
                                            : delta_ff;
      esum_wide = {error_sum_ff[fspid_pkg::ESUM_W-1], error_sum_ff}
                  + (fspid_pkg::ESUM_W+1)'($signed(err_ff));
   end

   always_comb begin
      if (sum_ff[fspid_pkg::SUM_W-1:fspid_pkg::ACC_W-1] == '0 ||
          sum_ff[fspid_pkg::SUM_W-1:fspid_pkg::ACC_W-1] == '1) begin
         sum_clamped = sum_ff[fspid_pkg::ACC_W-1:0];
      end else if (sum_ff[fspid_pkg::SUM_W-1]) begin
         sum_clamped = fspid_pkg::ACC_MIN;
      end else begin
         sum_clamped = fspid_pkg::ACC_MAX;
      end
   end

   // Integer part truncated toward zero.
   always_comb begin
      acc_int = fspid_pkg::ACC_W'($signed(acc_ff) >>> fspid_pkg::FRAC_BITS)
                + fspid_pkg::ACC_W'(acc_ff[fspid_pkg::ACC_W-1] &&
                                    (|acc_ff[fspid_pkg::FRAC_BITS-1:0]));
   end

   always_comb begin
      state_in      = state_ff;
      term_in       = term_ff;
      last_error_in = last_error_ff;
      error_sum_in  = error_sum_ff;
      acc_in        = acc_ff;
      target_in     = target_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      rpm_in        = rpm_ff;
      err_in        = err_ff;
      delta_in      = delta_ff;
      d_en_in       = d_en_ff;
      mcand_in      = mcand_ff;
      mul_hi_in     = mul_hi_ff;
      mul_lo_in     = mul_lo_ff;
      sum_in        = sum_ff;
      drive_in      = drive_ff;
      load_rsp      = 1'b0;

      case (state_ff)
         fspid_pkg::ST_IDLE: begin
            if (req_valid) begin
               target_in = req_target_rpm;
               dvd_in    = mag_x500;
               rem_in    = '0;
               cnt_in    = fspid_pkg::CNT_W'(fspid_pkg::DVD_W - 1);
               state_in  = fspid_pkg::ST_DIV;
            end
         end
         fspid_pkg::ST_DIV: begin
            rem_in = div_fit ? fspid_pkg::WIN_W'(div_trial - {1'b0, window_ff})
                             : div_trial[fspid_pkg::WIN_W-1:0];
            dvd_in = {dvd_ff[fspid_pkg::DVD_W-2:0], div_fit};
            cnt_in = cnt_ff - fspid_pkg::CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = fspid_pkg::ST_RPM;
            end
         end
         fspid_pkg::ST_RPM: begin
            if (window_ff == '0 || (|dvd_ff[fspid_pkg::DVD_W-1:fspid_pkg::RPM_W])) begin
               rpm_in = '1;
            end else begin
               rpm_in = dvd_ff[fspid_pkg::RPM_W-1:0];
            end
            if (target_ff == '0) begin
               drive_in = '0;
               state_in = fspid_pkg::ST_DONE;
            end else begin
               state_in = fspid_pkg::ST_ERR;
            end
         end
         fspid_pkg::ST_ERR: begin
            err_in   = fspid_pkg::ERR_W'({2'b00, target_ff}) - fspid_pkg::ERR_W'({2'b00, rpm_ff});
            state_in = fspid_pkg::ST_DELTA;
         end
         fspid_pkg::ST_DELTA: begin
            delta_in      = err_ff - last_error_ff;
            d_en_in       = $signed(err_ff) < $signed(fspid_pkg::ERR_W'($signed(error_thr_ff)));
            last_error_in = err_ff;
            state_in      = fspid_pkg::ST_INTEG;
         end
         fspid_pkg::ST_INTEG: begin
            if (adelta < {1'b0, delta_thr_ff}) begin
               if (esum_wide[fspid_pkg::ESUM_W] != esum_wide[fspid_pkg::ESUM_W-1]) begin
                  error_sum_in = {esum_wide[fspid_pkg::ESUM_W],
                                  {(fspid_pkg::ESUM_W-1){~esum_wide[fspid_pkg::ESUM_W]}}};
               end else begin
                  error_sum_in = esum_wide[fspid_pkg::ESUM_W-1:0];
               end
            end else begin
               error_sum_in = '0;
            end
            if ($signed(acc_ff) > $signed(fspid_pkg::ACC_TOP)) begin
               acc_in   = fspid_pkg::ACC_TOP;
               state_in = fspid_pkg::ST_DRV;
            end else if (acc_ff[fspid_pkg::ACC_W-1]) begin
               acc_in   = '0;
               state_in = fspid_pkg::ST_DRV;
            end else begin
               sum_in    = fspid_pkg::SUM_W'($signed(acc_ff));
               term_in   = fspid_pkg::TERM_P;
               mcand_in  = fspid_pkg::MC_W'($signed(err_ff));
               mul_hi_in = '0;
               mul_lo_in = gain_p_ff;
               cnt_in    = '1;
               state_in  = fspid_pkg::ST_MUL;
            end
         end
         fspid_pkg::ST_MUL: begin
            mul_hi_in = {mul_sum[fspid_pkg::HI_W-1], mul_sum[fspid_pkg::HI_W-1:1]};
            mul_lo_in = {mul_sum[0], mul_lo_ff[fspid_pkg::GAIN_W-1:1]};
            cnt_in    = cnt_ff - fspid_pkg::CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = fspid_pkg::ST_MADD;
            end
         end
         fspid_pkg::ST_MADD: begin
            sum_in    = sum_ff + term_value;
            mul_hi_in = '0;
            cnt_in    = '1;
            case (term_ff)
               fspid_pkg::TERM_P: begin
                  term_in   = fspid_pkg::TERM_I;
                  mcand_in  = error_sum_ff;
                  mul_lo_in = gain_i_ff;
                  state_in  = fspid_pkg::ST_MUL;
               end
               fspid_pkg::TERM_I: begin
                  if (d_en_ff) begin
                     term_in   = fspid_pkg::TERM_D;
                     mcand_in  = fspid_pkg::MC_W'($signed(delta_ff));
                     mul_lo_in = gain_d_ff;
                     state_in  = fspid_pkg::ST_MUL;
                  end else begin
                     state_in = fspid_pkg::ST_FIN;
                  end
               end
               default: begin
                  state_in = fspid_pkg::ST_FIN;
               end
            endcase
         end
         fspid_pkg::ST_FIN: begin
            acc_in   = sum_clamped;
            state_in = fspid_pkg::ST_DRV;
         end
         fspid_pkg::ST_DRV: begin
            if ($signed(acc_int) > $signed(fspid_pkg::DRIVE_MAX)) begin
               drive_in = fspid_pkg::DRIVE_W'(fspid_pkg::DRIVE_MAX);
            end else if ($signed(acc_int) < $signed(fspid_pkg::DRIVE_MIN)) begin
               drive_in = fspid_pkg::DRIVE_MIN[fspid_pkg::DRIVE_W-1:0];
            end else begin
               drive_in = acc_int[fspid_pkg::DRIVE_W-1:0];
            end
            state_in = fspid_pkg::ST_DONE;
         end
         fspid_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = fspid_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fspid_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_drive_in = rsp_drive_ff;
      rsp_rpm_in   = rsp_rpm_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_drive_in = drive_ff;
         rsp_rpm_in   = rpm_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fspid_pkg::ST_IDLE;
         term_ff       <= fspid_pkg::TERM_P;
         rsp_valid_ff  <= 1'b0;
         last_error_ff <= '0;
         error_sum_ff  <= '0;
         acc_ff        <= '0;
         cnt_ff        <= '0;
         window_ff     <= fspid_pkg::WINDOW_RST;
         delta_thr_ff  <= fspid_pkg::DELTA_THR_RST;
         error_thr_ff  <= fspid_pkg::ERROR_THR_RST;
         gain_p_ff     <= fspid_pkg::GAIN_P_RST;
         gain_i_ff     <= fspid_pkg::GAIN_I_RST;
         gain_d_ff     <= fspid_pkg::GAIN_D_RST;
      end else begin
         state_ff      <= state_in;
         term_ff       <= term_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
         acc_ff        <= acc_in;
         cnt_ff        <= cnt_in;
         if (csr_wr_en) begin
            case (csr_index)
               fspid_pkg::CSR_WINDOW:    window_ff    <= csr_wdata[fspid_pkg::WIN_W-1:0];
               fspid_pkg::CSR_DELTA_THR: delta_thr_ff <= csr_wdata[fspid_pkg::DTH_W-1:0];
               fspid_pkg::CSR_ERROR_THR: error_thr_ff <= csr_wdata[fspid_pkg::ETH_W-1:0];
               fspid_pkg::CSR_GAIN_P:    gain_p_ff    <= csr_wdata[fspid_pkg::GAIN_W-1:0];
               fspid_pkg::CSR_GAIN_I:    gain_i_ff    <= csr_wdata[fspid_pkg::GAIN_W-1:0];
               fspid_pkg::CSR_GAIN_D:    gain_d_ff    <= csr_wdata[fspid_pkg::GAIN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      rpm_ff       <= rpm_in;
      err_ff       <= err_in;
      delta_ff     <= delta_in;
      d_en_ff      <= d_en_in;
      mcand_ff     <= mcand_in;
      mul_hi_ff    <= mul_hi_in;
      mul_lo_ff    <= mul_lo_in;
      sum_ff       <= sum_in;
      drive_ff     <= drive_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_rpm_ff   <= rsp_rpm_in;
   end

   assign req_stall        = (state_ff != fspid_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_power  = rsp_drive_ff;
   assign rsp_measured_rpm = rsp_rpm_ff;

endmodule

### dv/flywheel_speed_pid_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flywheel speed PID unit testbench
// Drives encoder sample words and register writes into the unit. Each accepted
// word is run through a behavioral PID model held in a small scoreboard. Every
// drive and speed word that comes out is checked in order against that model.
// Both sides idle at random, and the receiver sometimes holds off for a long
// stretch so that the unit backs up.
// ----------------------------------------------------------------------------
module flywheel_speed_pid_unit_tb;
   import fspid_pkg::*;

   localparam int     HALF_PERIOD = 2;
   localparam int     HOLD_CYCLES = 600;
   localparam int     PHASES      = 10;
   localparam int     PHASE_WORDS = 105;
   localparam longint LIMIT_NS    = 6_000_000;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam longint ESUM_HIGH = 64'sd2147483647;
   localparam longint ESUM_LOW  = -64'sd2147483648;
   localparam longint ACC_HIGH  = (64'sd1 <<< 47) - 64'sd1;
   localparam longint ACC_LOW   = -(64'sd1 <<< 47);
   localparam longint TERM_CAP  = 64'sd1 <<< 52;
   localparam longint ACC_CEIL  = 64'sd127 <<< FRAC_BITS;

   class speed_pid_board;
      int     window;
      int     delta_thr;
      int     error_thr;
      longint kp;
      longint ki;
      longint kd;
      int     prev_error;
      int     error_sum;
      longint drive_acc;
      logic signed [DRIVE_W-1:0] drive_due[$];
      logic [RPM_W-1:0]          rpm_due[$];
      int     errors;

      function new();
         window     = int'(WINDOW_RST);
         delta_thr  = int'(DELTA_THR_RST);
         error_thr  = int'(ERROR_THR_RST);
         kp         = longint'({32'd0, GAIN_P_RST});
         ki         = longint'({32'd0, GAIN_I_RST});
         kd         = longint'({32'd0, GAIN_D_RST});
         prev_error = 0;
         error_sum  = 0;
         drive_acc  = 0;
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_WINDOW: begin
               window = int'(data[WIN_W-1:0]);
            end
            CSR_DELTA_THR: begin
               delta_thr = int'(data[DTH_W-1:0]);
            end
            CSR_ERROR_THR: begin
               error_thr = int'($signed(data[ETH_W-1:0]));
            end
            CSR_GAIN_P: begin
               kp = longint'({32'd0, data});
            end
            CSR_GAIN_I: begin
               ki = longint'({32'd0, data});
            end
            CSR_GAIN_D: begin
               kd = longint'({32'd0, data});
            end
            default: begin
            end
         endcase
      endfunction

      function void note_word(logic signed [TICK_W-1:0] ticks, logic [RPM_W-1:0] target);
         int     mag;
         int     err;
         int     dlt;
         int     adlt;
         longint q;
         longint sum;
         longint term;
         longint whole;
         logic [RPM_W-1:0]          rpm;
         logic signed [DRIVE_W-1:0] drive;
         mag = ticks < 0 ? -int'(ticks) : int'(ticks);
         if (window == 0) begin
            rpm = '1;
         end else begin
            q   = longint'(mag) * 500 / window;
            rpm = q > 65535 ? '1 : RPM_W'(q);
         end
         drive = '0;
         if (target != 0) begin
            err  = int'(target) - int'(rpm);
            dlt  = err - prev_error;
            adlt = dlt < 0 ? -dlt : dlt;
            if (adlt < delta_thr) begin
               sum = longint'(error_sum) + err;
               if (sum > ESUM_HIGH) begin
                  sum = ESUM_HIGH;
               end else if (sum < ESUM_LOW) begin
                  sum = ESUM_LOW;
               end
               error_sum = int'(sum);
            end else begin
               error_sum = 0;
            end
            if (drive_acc > ACC_CEIL) begin
               drive_acc = ACC_CEIL;
            end else if (drive_acc < 0) begin
               drive_acc = 0;
            end else begin
               term = longint'(error_sum) * ki;
               if (term > TERM_CAP) begin
                  term = TERM_CAP;
               end else if (term < -TERM_CAP) begin
                  term = -TERM_CAP;
               end
               sum = drive_acc + longint'(err) * kp + term;
               if (err < error_thr) begin
                  sum += longint'(dlt) * kd;
               end
               drive_acc = sum > ACC_HIGH ? ACC_HIGH : (sum < ACC_LOW ? ACC_LOW : sum);
            end
            prev_error = err;
            whole = drive_acc < 0 ? -((-drive_acc) >>> FRAC_BITS) : drive_acc >>> FRAC_BITS;
            if (whole > 32767) begin
               drive = 16'sh7FFF;
            end else if (whole < -32768) begin
               drive = 16'sh8000;
            end else begin
               drive = DRIVE_W'(whole);
            end
         end
         drive_due.push_back(drive);
         rpm_due.push_back(rpm);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 100) begin
            $display("ERROR at %0t ns: %s", $time, msg);
         end
      endtask

      task check_word(logic signed [DRIVE_W-1:0] drive, logic [RPM_W-1:0] rpm);
         logic signed [DRIVE_W-1:0] want_drive;
         logic [RPM_W-1:0]          want_rpm;
         if (rpm_due.size() == 0) begin
            report($sformatf("unexpected word: drive %0d rpm %0d", drive, rpm));
         end else begin
            want_drive = drive_due.pop_front();
            want_rpm   = rpm_due.pop_front();
            if (drive !== want_drive) begin
               report($sformatf("drive_power %0d, expected %0d", drive, want_drive));
            end
            if (rpm !== want_rpm) begin
               report($sformatf("measured_rpm %0d, expected %0d", rpm, want_rpm));
            end
         end
      endtask

      function int pending();
         return rpm_due.size();
      endfunction

      task close_out();
         if (rpm_due.size() != 0) begin
            report($sformatf("%0d words never came out", rpm_due.size()));
         end
      endtask
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic signed [TICK_W-1:0]    req_encoder_ticks;
   logic [RPM_W-1:0]            req_target_rpm;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [DRIVE_W-1:0]   rsp_drive_power;
   logic [RPM_W-1:0]            rsp_measured_rpm;
   logic                        csr_wr_en;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;

   speed_pid_board board;
   bit             calm;
   int             hold_req;

   flywheel_speed_pid_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_encoder_ticks (req_encoder_ticks),
      .req_target_rpm    (req_target_rpm),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive_power   (rsp_drive_power),
      .rsp_measured_rpm  (rsp_measured_rpm),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   initial begin
      #LIMIT_NS;
      $display("flywheel_speed_pid_unit test failed");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 15);
      if (calm || r < 9) begin
         return 0;
      end else if (r < 14) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain(logic [GAIN_W-1:0] rst_value);
      case ($urandom_range(0, 5))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2: begin
            return rst_value;
         end
         3: begin
            return $urandom_range(1, 4096);
         end
         4: begin
            return $urandom_range(1024, 1 << 20);
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         board.check_word(rsp_drive_power, rsp_measured_rpm);
      end
   end

   initial begin : receiver
      int n;
      int holds_done;
      holds_done = 0;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req != holds_done) begin
            holds_done = holds_done + 1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            n = gap_len();
            rsp_stall <= (n > 0);
            repeat (n > 0 ? n : $urandom_range(1, 4)) @(negedge clock);
         end
      end
   end

   task send_word(input logic signed [TICK_W-1:0] ticks, input logic [RPM_W-1:0] target);
      req_valid         <= 1'b1;
      req_encoder_ticks <= ticks;
      req_target_rpm    <= target;
      do @(posedge clock); while (req_stall);
      board.note_word(ticks, target);
      @(negedge clock);
   endtask

   task idle_for(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   task put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.write_reg(idx, data);
      @(negedge clock);
   endtask

   // Upper bits beyond each register's width carry noise that must be ignored.
   task apply_settings(input logic [31:0] win, input logic [31:0] dthr, input logic [31:0] ethr,
                       input logic [31:0] gp, input logic [31:0] gi, input logic [31:0] gd);
      logic [31:0] noise;
      noise = $urandom;
      put_reg(CSR_WINDOW, {noise[31:WIN_W], win[WIN_W-1:0]});
      noise = $urandom;
      put_reg(CSR_DELTA_THR, {noise[31:DTH_W], dthr[DTH_W-1:0]});
      noise = $urandom;
      put_reg(CSR_ERROR_THR, {noise[31:ETH_W], ethr[ETH_W-1:0]});
      put_reg(CSR_GAIN_P, gp);
      put_reg(CSR_GAIN_I, gi);
      put_reg(CSR_GAIN_D, gd);
      put_reg($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, $urandom);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      int win;
      int dthr;
      int ethr;
      int est;
      int tgt;
      int seq_ticks;
      int seq_target;
      int r;
      int n;
      logic signed [TICK_W-1:0] ticks;
      logic [RPM_W-1:0]         target;
      board             = new();
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_encoder_ticks = '0;
      req_target_rpm    = '0;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_WINDOW;
      csr_wdata         = '0;
      calm              = 1'b0;
      hold_req          = 0;
      seq_ticks         = 0;
      seq_target        = 1;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Registers at their reset values, zero target, extreme ticks and targets.
      send_word(16'sd0, 16'd0);
      send_word(16'sd32767, 16'd0);
      send_word(-16'sd32768, 16'd0);
      send_word(16'sd0, 16'd1);
      send_word(16'sd0, 16'd65535);
      send_word(-16'sd32768, 16'd65535);
      send_word(16'sd4, 16'd100);
      send_word(16'sd4, 16'd100);
      idle_for(3);
      send_word(16'sd4, 16'd100);
      send_word(16'sd5, 16'd100);
      send_word(-16'sd4, 16'd101);
      send_word(16'sd2620, 16'd65535);
      send_word(16'sd32767, 16'd1);
      drain();

      // A zero window reads as full speed.
      apply_settings(0, 131071, 32'h0001_0000, '1, '1, '1);
      send_word(16'sd1, 16'd65535);
      send_word(-16'sd1, 16'd65535);
      send_word(16'sd0, 16'd1);
      send_word(16'sd100, 16'd0);
      drain();

      // A window past the nominal range still divides.
      apply_settings(1023, 0, 65535, '0, '0, '0);
      send_word(16'sd32767, 16'd65535);
      send_word(-16'sd32768, 16'd300);
      send_word(16'sd1000, 16'd16000);
      drain();

      // A one-millisecond window saturates the speed quickly.
      apply_settings(1, 131071, 65535, '1, '1, '1);
      send_word(16'sd200, 16'd65535);
      send_word(-16'sd1, 16'd1);
      send_word(16'sd0, 16'd65535);
      send_word(16'sd0, 16'd65535);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 5))
            0: win = 1;
            1: win = 1000;
            2: win = 0;
            3: win = $urandom_range(1001, 1023);
            4: win = 20;
            default: win = $urandom_range(1, 100);
         endcase
         case ($urandom_range(0, 4))
            0: dthr = 0;
            1: dthr = 131071;
            2: dthr = $urandom_range(1, 2000);
            3: dthr = $urandom_range(0, 131071);
            default: dthr = 50;
         endcase
         case ($urandom_range(0, 5))
            0: ethr = -65535;
            1: ethr = 65535;
            2: ethr = -65536;
            3: ethr = 100;
            default: ethr = $urandom_range(0, 131070) - 65535;
         endcase
         apply_settings(win, dthr, ethr, pick_gain(GAIN_P_RST), pick_gain(GAIN_I_RST),
                        pick_gain(GAIN_D_RST));
         calm = (p == 3 || p == 7);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if ((p == 2 || p == 6) && i == 30) begin
               hold_req = hold_req + 1;
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
               ticks  = TICK_W'($urandom);
               target = '0;
            end else if (r < 22) begin
               ticks  = TICK_W'($urandom);
               target = RPM_W'($urandom);
            end else begin
               if (i % 20 == 0 || r < 25) begin
                  seq_ticks = $urandom_range(0, 400) - 200;
                  if (win == 0) begin
                     est = 65535;
                  end else begin
                     est = (seq_ticks < 0 ? -seq_ticks : seq_ticks) * 500 / win;
                     est = est > 65535 ? 65535 : est;
                  end
                  tgt = est + $urandom_range(0, 200) - 100;
                  seq_target = tgt < 1 ? 1 : (tgt > 65535 ? 65535 : tgt);
               end else begin
                  seq_ticks = seq_ticks + $urandom_range(0, 4) - 2;
                  if ($urandom_range(0, 9) == 0) begin
                     tgt = seq_target + $urandom_range(0, 40) - 20;
                     seq_target = tgt < 1 ? 1 : (tgt > 65535 ? 65535 : tgt);
                  end
               end
               ticks  = TICK_W'(seq_ticks);
               target = RPM_W'(seq_target);
            end
            send_word(ticks, target);
            idle_for(gap_len());
         end
         drain();
         calm = 1'b0;
      end

      req_valid <= 1'b0;
      n = 0;
      while (board.pending() != 0 && n < 20000) begin
         @(negedge clock);
         n++;
      end
      repeat (200) @(negedge clock);
      board.close_out();
      if (board.errors == 0) begin
         $display("flywheel_speed_pid_unit test passed");
      end else begin
         $display("flywheel_speed_pid_unit test failed");
      end
      $finish;
   end

endmodule
